// File: rtl/bgc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// bgc_pkg: shared types and constants of the button gesture classifier
// Register indexes, result record, configuration bundle and reset defaults.
// -----------------------------------------------------------------------------
package bgc_pkg;

	localparam int TIME_BITS_DEF = 32;
	localparam int MAX_RESULTS   = 3;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_BUTTON_ID     = 3'd0,
		REG_POLLING_EN    = 3'd1,
		REG_POSITIONING   = 3'd2,
		REG_MULTI_TAP     = 3'd3,
		REG_TAP_WINDOW    = 3'd4,
		REG_LONG_PRESS    = 3'd5,
		REG_DEBOUNCE      = 3'd6,
		REG_TASK_PERIOD   = 3'd7
	} reg_idx_t;

	typedef enum logic {
		EV_STATE  = 1'b0,
		EV_ACTION = 1'b1
	} ev_kind_t;

	typedef enum logic [1:0] {
		ACT_TAP       = 2'd0,
		ACT_LONG      = 2'd1,
		ACT_POS_START = 2'd2,
		ACT_POS_STOP  = 2'd3
	} act_t;

	localparam logic [7:0]  TAP_MAX          = 8'd254;
	localparam logic [15:0] BUTTON_ID_RST    = 16'd0;
	localparam logic [15:0] TAP_WINDOW_RST   = 16'd300;
	localparam logic [15:0] LONG_PRESS_RST   = 16'd800;
	localparam logic [15:0] DEBOUNCE_RST     = 16'd50;
	localparam logic [7:0]  TASK_PERIOD_RST  = 8'd10;

	typedef struct packed {
		logic [15:0] button_id;
		logic        polling_en;
		logic        positioning_en;
		logic        multi_tap_en;
		logic [15:0] tap_window;
		logic [15:0] long_press;
		logic [15:0] debounce;
		logic [7:0]  task_period;
	} cfg_t;

	typedef struct packed {
		ev_kind_t    kind;
		logic [15:0] code;
		logic        state;
		act_t        act;
		logic [7:0]  cnt;
	} result_t;

	// all results of one item, handed from the core to the result queue
	typedef struct packed {
		logic         load;
		logic [1:0]   n;
		result_t [MAX_RESULTS-1:0] items;
	} batch_t;

endpackage
`default_nettype wire

// File: rtl/bgc_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// bgc_ifs: valid/ready channels of the button gesture classifier
// Input channel carries one tick or level change, output channel one event.
// -----------------------------------------------------------------------------
interface bgc_in_if;
	logic valid;
	logic ready;
	logic req_type;
	logic level;

	modport source (output valid, output req_type, output level, input ready);
	modport sink   (input valid, input req_type, input level, output ready);
endinterface

interface bgc_out_if;
	logic        valid;
	logic        ready;
	logic        event_kind;
	logic [15:0] button_code;
	logic        new_state;
	logic [1:0]  action_code;
	logic [7:0]  tap_count;
	logic        last;

	modport source (output valid, output event_kind, output button_code, output new_state,
		output action_code, output tap_count, output last, input ready);
	modport sink   (input valid, input event_kind, input button_code, input new_state,
		input action_code, input tap_count, input last, output ready);
endinterface
`default_nettype wire

// File: rtl/bgc_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// bgc_cfg: configuration register file
// Decodes plain register writes into the configuration bundle.
// -----------------------------------------------------------------------------
module bgc_cfg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire logic [2:0]    index,
	input  wire logic [15:0]   data,
	output bgc_pkg::cfg_t      cfg
);

	bgc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.button_id      <= bgc_pkg::BUTTON_ID_RST;
			cfg_q.polling_en     <= 1'b1;
			cfg_q.positioning_en <= 1'b0;
			cfg_q.multi_tap_en   <= 1'b0;
			cfg_q.tap_window     <= bgc_pkg::TAP_WINDOW_RST;
			cfg_q.long_press     <= bgc_pkg::LONG_PRESS_RST;
			cfg_q.debounce       <= bgc_pkg::DEBOUNCE_RST;
			cfg_q.task_period    <= bgc_pkg::TASK_PERIOD_RST;
		end else if (wr_en) begin
			unique case (bgc_pkg::reg_idx_t'(index))
				bgc_pkg::REG_BUTTON_ID:   cfg_q.button_id      <= data;
				bgc_pkg::REG_POLLING_EN:  cfg_q.polling_en     <= data[0];
				bgc_pkg::REG_POSITIONING: cfg_q.positioning_en <= data[0];
				bgc_pkg::REG_MULTI_TAP:   cfg_q.multi_tap_en   <= data[0];
				bgc_pkg::REG_TAP_WINDOW:  cfg_q.tap_window     <= data;
				bgc_pkg::REG_LONG_PRESS:  cfg_q.long_press     <= data;
				bgc_pkg::REG_DEBOUNCE:    cfg_q.debounce       <= data;
				bgc_pkg::REG_TASK_PERIOD: cfg_q.task_period    <= data[7:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// File: rtl/bgc_core.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// bgc_core: input register, gesture state and single-pass classification
// Evaluates one registered item per cycle while q_free and hands its results over as a batch.
// -----------------------------------------------------------------------------
module bgc_core #(
	parameter int TIME_BITS = bgc_pkg::TIME_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	bgc_in_if.sink             in_ch,
	input  wire bgc_pkg::cfg_t cfg,
	input  wire logic          q_free,
	output bgc_pkg::batch_t    batch
);

	typedef logic [TIME_BITS-1:0] tm_t;

	// elapsed time clamped to 16 bits
	function automatic logic [15:0] sat16(input tm_t d);
		tm_t hi;
		hi = d >> 16;
		return (hi != '0) ? 16'hFFFF : d[15:0];
	endfunction

	logic v_s1;
	logic type_s1;
	logic lvl_s1;

	tm_t        now_q, last_task_q, last_bounce_q, pstart_q, pend_q;
	logic       prev_q, stable_q, pev_q, pos_q, cp_q;
	logic [7:0] taps_q;

	tm_t        now_n, last_task_n, last_bounce_n, pstart_n, pend_n;
	logic       prev_n, stable_n, pev_n, pos_n, cp_n;
	logic [7:0] taps_n;

	logic proc;
	tm_t  now_inc, t_evt;
	logic due, poll, deb, lc, merge, pend_set;
	logic [15:0] gap_task, gap_bounce, gap_ps_old, gap_pe_old, gap_ps, gap_pe;
	bgc_pkg::result_t [bgc_pkg::MAX_RESULTS-1:0] res;
	logic [1:0] k;

	assign proc        = v_s1 && q_free;
	assign in_ch.ready = !v_s1 || q_free;

	// input register: take a new item whenever the current one moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			type_s1 <= in_ch.req_type;
			lvl_s1  <= in_ch.level;
		end
	end

	assign now_inc    = tm_t'(now_q + 1'b1);
	assign t_evt      = type_s1 ? now_q : now_inc;
	assign gap_task   = sat16(tm_t'(now_inc - last_task_q));
	assign gap_bounce = sat16(tm_t'(now_inc - last_bounce_q));
	assign gap_ps_old = sat16(tm_t'(now_inc - pstart_q));
	assign gap_pe_old = sat16(tm_t'(now_inc - pend_q));

	assign due   = !type_s1 && (gap_task >= {8'd0, cfg.task_period});
	assign poll  = due && cfg.polling_en;
	// a changed raw level restarts the bounce timer, so it cannot pass this time
	assign deb   = poll && (lvl_s1 == prev_q) && (gap_bounce > cfg.debounce)
		&& (lvl_s1 != stable_q);
	assign lc    = type_s1 || deb;
	assign merge = pev_q && (tm_t'(t_evt - pend_q) <= tm_t'(cfg.tap_window));

	always_comb begin
		now_n         = now_q;
		last_task_n   = last_task_q;
		last_bounce_n = last_bounce_q;
		pstart_n      = pstart_q;
		pend_n        = pend_q;
		prev_n        = prev_q;
		stable_n      = stable_q;
		pev_n         = pev_q;
		pos_n         = pos_q;
		cp_n          = cp_q;
		taps_n        = taps_q;
		pend_set      = 1'b0;
		res           = '0;
		k             = 2'd0;

		if (!type_s1) begin
			now_n = now_inc;
		end
		if (due) begin
			last_task_n = now_inc;
		end
		if (poll && (lvl_s1 != prev_q)) begin
			last_bounce_n = now_inc;
		end
		if (type_s1 || poll) begin
			prev_n = lvl_s1;
		end

		// stable level change
		if (lc) begin
			stable_n = lvl_s1;
			res[k]   = '{bgc_pkg::EV_STATE, cfg.button_id, lvl_s1, bgc_pkg::ACT_TAP, 8'd0};
			k        = k + 2'd1;
			if (lvl_s1) begin
				if (merge) begin
					if (taps_q < bgc_pkg::TAP_MAX) begin
						taps_n = taps_q + 8'd1;
					end
					pend_n = '0;
					pev_n  = 1'b0;
				end else begin
					taps_n = 8'd1;
				end
				pos_n    = 1'b0;
				pstart_n = t_evt;
				cp_n     = 1'b1;
			end else begin
				if (pos_q) begin
					res[k] = '{bgc_pkg::EV_ACTION, cfg.button_id, 1'b0,
						bgc_pkg::ACT_POS_STOP, 8'd1};
					k      = k + 2'd1;
					pos_n  = 1'b0;
					taps_n = 8'd0;
				end
				if (taps_n != 8'd0) begin
					pend_n   = t_evt;
					pev_n    = 1'b1;
					cp_n     = 1'b1;
					pend_set = 1'b1;
				end
			end
		end

		// timestamps written just now give zero elapsed time
		gap_ps = (lc && lvl_s1) ? 16'd0 : gap_ps_old;
		gap_pe = pend_set ? 16'd0 : gap_pe_old;

		// pending gesture check
		if (due && cp_n) begin
			if (gap_ps >= cfg.long_press) begin
				res[k] = '{bgc_pkg::EV_ACTION, cfg.button_id, 1'b0,
					cfg.positioning_en ? bgc_pkg::ACT_POS_START : bgc_pkg::ACT_LONG, 8'd1};
				k        = k + 2'd1;
				pstart_n = '0;
				pend_n   = '0;
				pev_n    = 1'b0;
				taps_n   = 8'd0;
				cp_n     = 1'b0;
				if (cfg.positioning_en) begin
					pos_n = 1'b1;
				end
			end else if (pev_n && ((gap_pe >= cfg.tap_window) || !cfg.multi_tap_en)) begin
				res[k] = '{bgc_pkg::EV_ACTION, cfg.button_id, 1'b0, bgc_pkg::ACT_TAP, taps_n};
				k        = k + 2'd1;
				pstart_n = '0;
				pend_n   = '0;
				pev_n    = 1'b0;
				taps_n   = 8'd0;
				cp_n     = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q         <= '0;
			last_task_q   <= '0;
			last_bounce_q <= '0;
			pstart_q      <= '0;
			pend_q        <= '0;
			prev_q        <= 1'b0;
			stable_q      <= 1'b0;
			pev_q         <= 1'b0;
			pos_q         <= 1'b0;
			cp_q          <= 1'b0;
			taps_q        <= 8'd0;
		end else if (proc) begin
			now_q         <= now_n;
			last_task_q   <= last_task_n;
			last_bounce_q <= last_bounce_n;
			pstart_q      <= pstart_n;
			pend_q        <= pend_n;
			prev_q        <= prev_n;
			stable_q      <= stable_n;
			pev_q         <= pev_n;
			pos_q         <= pos_n;
			cp_q          <= cp_n;
			taps_q        <= taps_n;
		end
	end

	assign batch.load  = proc;
	assign batch.n     = k;
	assign batch.items = res;

endmodule
`default_nettype wire

// File: rtl/bgc_resq.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// bgc_resq: result queue
// Holds the results of one item and sends them out one per cycle while out_ch.ready is high.
// -----------------------------------------------------------------------------
module bgc_resq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire bgc_pkg::batch_t batch,
	output logic                 q_free,
	bgc_out_if.source            out_ch
);

	bgc_pkg::result_t [bgc_pkg::MAX_RESULTS-1:0] ent_q;
	logic [1:0] n_q;
	logic       take;

	assign take   = out_ch.valid && out_ch.ready;
	assign q_free = (n_q == 2'd0) || ((n_q == 2'd1) && take);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= 2'd0;
		end else if (batch.load) begin
			n_q <= batch.n;
		end else if (take) begin
			n_q <= n_q - 2'd1;
		end
	end

	// shift toward the head as results leave
	always_ff @(posedge clk) begin
		if (batch.load) begin
			ent_q <= batch.items;
		end else if (take) begin
			ent_q[0] <= ent_q[1];
			ent_q[1] <= ent_q[2];
		end
	end

	assign out_ch.valid       = (n_q != 2'd0);
	assign out_ch.event_kind  = ent_q[0].kind;
	assign out_ch.button_code = ent_q[0].code;
	assign out_ch.new_state   = ent_q[0].state;
	assign out_ch.action_code = ent_q[0].act;
	assign out_ch.tap_count   = ent_q[0].cnt;
	assign out_ch.last        = (n_q == 2'd1);

endmodule
`default_nettype wire

// File: rtl/button_gesture_classifier_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// button_gesture_classifier_unit: tap / long press / positioning detector
// Debounces a polled button or takes external level changes, counts taps and
// reports state changes and gestures for one button.
//
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+--------------------------------------------
//  in_ch    | in  | valid / ready  | req_type, level
//  out_ch   | out | valid / ready  | event_kind, button_code, new_state,
//           |     |                | action_code, tap_count, last
//  cfg_*    | in  | cfg_wr_en only | cfg_index, cfg_data (16 bit)
//
//  An item is held in the input register, then combinational logic produces
//  all its results (zero to two) into the result queue.
//  The queue sends one result per cycle while out_ch.ready is high, and it
//  takes the results of the next item only once it is empty or the last
//  result of the current item leaves.
//  Reset clears all timers and gesture state and loads register defaults;
//  no clearing pass follows.
//  A stalled output holds its result; an empty input register takes an item.
// -----------------------------------------------------------------------------
module button_gesture_classifier_unit #(
	parameter int TIME_BITS = bgc_pkg::TIME_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	bgc_in_if.sink           in_ch,
	bgc_out_if.source        out_ch
);

	bgc_pkg::cfg_t   cfg;
	bgc_pkg::batch_t batch;
	logic            q_free;

	// register file: user writes only while the block is idle, not enforced
	bgc_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	// input register, millisecond clock, debounce and gesture state;
	// advance only when the queue can take the whole batch
	bgc_core #(
		.TIME_BITS (TIME_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.cfg    (cfg),
		.q_free (q_free),
		.batch  (batch)
	);

	// result queue: drain one result per ready cycle, flag the final one
	bgc_resq u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.batch  (batch),
		.q_free (q_free),
		.out_ch (out_ch)
	);

endmodule
`default_nettype wire

// File: rtl/bgc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// bgc_checker: port-level checks of the button gesture classifier
// Output handshake and result field consistency, bound to the top level.
// -----------------------------------------------------------------------------
module bgc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        event_kind,
	input wire logic [15:0] button_code,
	input wire logic        new_state,
	input wire logic [1:0]  action_code,
	input wire logic [7:0]  tap_count,
	input wire logic        last
);

	// hold a stalled item
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output valid dropped while stalled");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable({event_kind, button_code, new_state,
			action_code, tap_count, last}))
		else $error("output payload changed while stalled");

	// a result that is not the last one of its input has a follower queued
	a_burst_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid)
		else $error("result burst ended without last");

	// state events carry no action; actions carry a count and no level
	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (event_kind == 1'b0 && action_code == 2'd0 && tap_count == 8'd0)
			|| (event_kind == 1'b1 && new_state == 1'b0 && tap_count != 8'd0
				&& (action_code == 2'd0 || tap_count == 8'd1)))
		else $error("inconsistent result fields");

endmodule

bind button_gesture_classifier_unit bgc_checker u_bgc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.event_kind  (out_ch.event_kind),
	.button_code (out_ch.button_code),
	.new_state   (out_ch.new_state),
	.action_code (out_ch.action_code),
	.tap_count   (out_ch.tap_count),
	.last        (out_ch.last)
);
`default_nettype wire

// File: tb/button_gesture_classifier_unit_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// button_gesture_classifier_unit_tb: self-checking bench for the gesture unit
// Feeds ticks and external level changes under random flow control. A local
// model of the debounce, tap counting and hold timing predicts every event,
// and a small scoreboard checks each event the unit sends.
// -----------------------------------------------------------------------------
module button_gesture_classifier_unit_tb;
	import bgc_pkg::*;

	localparam logic REQ_TICK       = 1'b0;
	localparam logic REQ_EXT        = 1'b1;
	localparam int   RESET_CYCLES   = 12;
	localparam int   SETTLE_CYCLES  = 8;
	localparam int   WATCHDOG_LIMIT = 2000;
	localparam int   RANDOM_ITEMS   = 260;

	// one predicted or observed event, with its end-of-item flag
	typedef struct packed {
		result_t ev;
		logic    last;
	} event_rec_t;

	// Gesture model plus the queue of events still owed by the unit.
	class gesture_scoreboard;
		cfg_t        cfg;
		logic [31:0] now_ms, eval_ms, bounce_ms, press_ms, release_ms;
		logic        raw_q, stable_q, release_ok, positioning, pending;
		logic [7:0]  taps;
		event_rec_t  due[$];
		event_rec_t  batch[$];
		int          errors;
		int          checked;

		function new();
			cfg.button_id      = BUTTON_ID_RST;
			cfg.polling_en     = 1'b1;
			cfg.positioning_en = 1'b0;
			cfg.multi_tap_en   = 1'b0;
			cfg.tap_window     = TAP_WINDOW_RST;
			cfg.long_press     = LONG_PRESS_RST;
			cfg.debounce       = DEBOUNCE_RST;
			cfg.task_period    = TASK_PERIOD_RST;
			now_ms      = '0;
			eval_ms     = '0;
			bounce_ms   = '0;
			raw_q       = 1'b0;
			stable_q    = 1'b0;
			positioning = 1'b0;
			errors      = 0;
			checked     = 0;
			clear_gesture();
		endfunction

		function void write_reg(reg_idx_t idx, logic [15:0] d);
			case (idx)
				REG_BUTTON_ID:   cfg.button_id      = d;
				REG_POLLING_EN:  cfg.polling_en     = d[0];
				REG_POSITIONING: cfg.positioning_en = d[0];
				REG_MULTI_TAP:   cfg.multi_tap_en   = d[0];
				REG_TAP_WINDOW:  cfg.tap_window     = d;
				REG_LONG_PRESS:  cfg.long_press     = d;
				REG_DEBOUNCE:    cfg.debounce       = d;
				REG_TASK_PERIOD: cfg.task_period    = d[7:0];
				default: ;
			endcase
		endfunction

		function logic [31:0] elapsed(logic [31:0] t);
			return now_ms - t;
		endfunction

		// thresholds see the gap clipped to 16 bits, never wrapped
		function logic [31:0] elapsed_sat(logic [31:0] t);
			logic [31:0] d;
			d = now_ms - t;
			return (d > 32'd65535) ? 32'd65535 : d;
		endfunction

		function void emit(ev_kind_t k, logic st, act_t a, logic [7:0] c);
			event_rec_t e;
			if (batch.size() >= MAX_RESULTS)
				return;
			e.ev.kind  = k;
			e.ev.code  = cfg.button_id;
			e.ev.state = st;
			e.ev.act   = a;
			e.ev.cnt   = c;
			e.last     = 1'b0;
			batch.push_back(e);
		endfunction

		function void clear_gesture();
			press_ms   = '0;
			release_ms = '0;
			release_ok = 1'b0;
			taps       = '0;
			pending    = 1'b0;
		endfunction

		// new stable level: report it, then start or close a press
		function void take_level(logic s);
			stable_q = s;
			emit(EV_STATE, s, ACT_TAP, 8'd0);
			if (s) begin
				// the tap gap test uses the raw, unclipped difference
				if (release_ok && elapsed(release_ms) <= {16'd0, cfg.tap_window}) begin
					if (taps < TAP_MAX)
						taps++;
					release_ms = '0;
					release_ok = 1'b0;
				end else begin
					taps = 8'd1;
				end
				positioning = 1'b0;
				press_ms    = now_ms;
				pending     = 1'b1;
			end else begin
				if (positioning) begin
					emit(EV_ACTION, 1'b0, ACT_POS_STOP, 8'd1);
					positioning = 1'b0;
					taps        = '0;
				end
				if (taps != 0) begin
					release_ms = now_ms;
					release_ok = 1'b1;
					pending    = 1'b1;
				end
			end
		endfunction

		// hold timing wins over tap confirmation; both use the clipped gap
		function void classify();
			if (!pending)
				return;
			if (elapsed_sat(press_ms) >= cfg.long_press) begin
				if (cfg.positioning_en) begin
					emit(EV_ACTION, 1'b0, ACT_POS_START, 8'd1);
					clear_gesture();
					positioning = 1'b1;
				end else begin
					emit(EV_ACTION, 1'b0, ACT_LONG, 8'd1);
					clear_gesture();
				end
				return;
			end
			if (release_ok && (elapsed_sat(release_ms) >= cfg.tap_window || !cfg.multi_tap_en)) begin
				emit(EV_ACTION, 1'b0, ACT_TAP, taps);
				clear_gesture();
			end
		endfunction

		function void note_item(logic rt, logic lv);
			event_rec_t e;
			batch.delete();
			if (rt == REQ_EXT) begin
				take_level(lv);
				raw_q = lv;
			end else begin
				now_ms++;
				if (elapsed_sat(eval_ms) >= cfg.task_period) begin
					eval_ms = now_ms;
					if (cfg.polling_en) begin
						if (lv != raw_q)
							bounce_ms = now_ms;
						if (elapsed_sat(bounce_ms) > cfg.debounce && lv != stable_q)
							take_level(lv);
						raw_q = lv;
					end
					classify();
				end
			end
			for (int i = 0; i < batch.size(); i++) begin
				e = batch[i];
				e.last = (i == batch.size() - 1);
				due.push_back(e);
			end
		endfunction

		function int outstanding();
			return due.size();
		endfunction

		task report(string msg);
			errors++;
			$display("%0t ERROR %s", $time, msg);
		endtask

		task compare(string name, logic [15:0] got, logic [15:0] want);
			if (got !== want)
				report($sformatf("%s: got %0h, expected %0h", name, got, want));
		endtask

		task check_result(event_rec_t got);
			event_rec_t want;
			if (due.size() == 0) begin
				report($sformatf("event with none expected: kind %0d act %0d count %0d",
					got.ev.kind, got.ev.act, got.ev.cnt));
				return;
			end
			want = due.pop_front();
			checked++;
			compare("event_kind", got.ev.kind, want.ev.kind);
			compare("button_code", got.ev.code, want.ev.code);
			compare("new_state", got.ev.state, want.ev.state);
			compare("action_code", got.ev.act, want.ev.act);
			compare("tap_count", got.ev.cnt, want.ev.cnt);
			compare("last", got.last, want.last);
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	reg_idx_t    cfg_index;
	logic [15:0] cfg_data;

	bgc_in_if  in_ch();
	bgc_out_if out_ch();

	gesture_scoreboard sb = new();

	// flow control knobs: largest gap the sender and the receiver may draw
	int send_gap_max  = 11;
	int rcv_stall_max = 11;
	int items_sent    = 0;
	int quiet_cycles  = 0;
	event_rec_t seen;

	button_gesture_classifier_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	always #1 clk = ~clk;

	// Receiver: draw a stall before each event, then hold ready until one is taken.
	initial begin
		int stall;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = $urandom_range(0, rcv_stall_max);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!out_ch.valid) @(posedge clk);
		end
	end

	// Check every event at the edge where it is taken.
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			seen.ev.kind  = ev_kind_t'(out_ch.event_kind);
			seen.ev.code  = out_ch.button_code;
			seen.ev.state = out_ch.new_state;
			seen.ev.act   = act_t'(out_ch.action_code);
			seen.ev.cnt   = out_ch.tap_count;
			seen.last     = out_ch.last;
			sb.check_result(seen);
		end
	end

	// Watchdog: any handshake on either side counts as progress.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("%0t timeout: no progress for %0d cycles", $time, quiet_cycles);
					$display("FAILED: results differ");
					$finish;
				end
			end
		end
	end

	// Offer one item after a random gap; return at the edge where it is taken.
	task automatic send_item(logic rt, logic lv);
		int gap;
		gap = $urandom_range(0, send_gap_max);
		@(negedge clk);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid    <= 1'b1;
		in_ch.req_type <= rt;
		in_ch.level    <= lv;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sb.note_item(rt, lv);
		items_sent++;
	endtask

	// Hold the raw button level for n ticks; the first few ticks chatter.
	task automatic hold_level(logic lv, int n, int bounce);
		for (int k = 0; k < n; k++)
			send_item(REQ_TICK, (k < bounce) ? 1'($urandom_range(0, 1)) : lv);
	endtask

	// Stop sending, wait for every owed event, then let the pipeline empty.
	task automatic drain();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [15:0] d);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		sb.write_reg(idx, d);
	endtask

	// Rewrite all registers while idle; unused high bits carry junk on purpose.
	task automatic set_config(logic [15:0] id, logic poll, logic pos, logic multi,
			logic [15:0] win, logic [15:0] hold, logic [15:0] deb, logic [7:0] period);
		drain();
		write_reg(REG_BUTTON_ID, id);
		write_reg(REG_POLLING_EN, {15'($urandom), poll});
		write_reg(REG_POSITIONING, {15'($urandom), pos});
		write_reg(REG_MULTI_TAP, {15'($urandom), multi});
		write_reg(REG_TAP_WINDOW, win);
		write_reg(REG_LONG_PRESS, hold);
		write_reg(REG_DEBOUNCE, deb);
		write_reg(REG_TASK_PERIOD, {8'($urandom), period});
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// One random gesture sized from the current hold and window settings.
	task automatic random_gesture();
		int pick;
		int hold;
		int win;
		hold = sb.cfg.long_press;
		win  = sb.cfg.tap_window;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			// polled presses, possibly a quick multi-tap burst
			repeat ($urandom_range(1, 3)) begin
				hold_level(1'b1, $urandom_range(1, hold + 12), $urandom_range(0, 3));
				hold_level(1'b0, $urandom_range(1, win + 12), $urandom_range(0, 3));
			end
		end else if (pick < 85) begin
			// interrupt-driven press and release with time passing between
			send_item(REQ_EXT, 1'b1);
			hold_level(1'b1, $urandom_range(0, hold + 6), 0);
			send_item(REQ_EXT, 1'b0);
			hold_level(1'b0, $urandom_range(0, win + 6), 0);
		end else begin
			repeat ($urandom_range(1, 8))
				send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		int base_items;
		int phase_start;
		int phase_len;

		arst_n         = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_index      = REG_BUTTON_ID;
		cfg_data       = '0;
		in_ch.valid    = 1'b0;
		in_ch.req_type = REQ_TICK;
		in_ch.level    = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: repeated external press, release, then a tap is
		// confirmed at the next evaluation.
		send_item(REQ_EXT, 1'b1);
		send_item(REQ_EXT, 1'b1);
		send_item(REQ_EXT, 1'b0);
		hold_level(1'b0, 10, 0);

		// All thresholds zero, evaluation on every tick, positioning on:
		// positioning start, a press during positioning, positioning stop.
		set_config(16'hFFFF, 1'b1, 1'b1, 1'b1, 16'd0, 16'd0, 16'd0, 8'd0);
		hold_level(1'b1, 2, 0);
		send_item(REQ_EXT, 1'b1);
		hold_level(1'b1, 1, 0);
		send_item(REQ_EXT, 1'b0);
		hold_level(1'b0, 2, 0);

		// A burst of taps with no time between, counted as one sequence.
		set_config(16'h5A5A, 1'b0, 1'b0, 1'b1, 16'd5, 16'd1000, 16'hFFFF, 8'd1);
		repeat (24) begin
			send_item(REQ_EXT, 1'b1);
			send_item(REQ_EXT, 1'b0);
		end
		hold_level(1'b0, 8, 0);

		// Largest thresholds and a period of 254: a short hold completes no gesture.
		set_config(16'h8001, 1'b1, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd254);
		send_item(REQ_EXT, 1'b1);
		hold_level(1'b1, 16, 0);
		send_item(REQ_EXT, 1'b0);
		hold_level(1'b0, 4, 0);

		// Random phases with small thresholds so gestures finish quickly.
		base_items = items_sent;
		while (items_sent - base_items < RANDOM_ITEMS) begin
			set_config(16'($urandom), 1'($urandom_range(0, 4) != 0), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 16'($urandom_range(0, 20)),
				16'($urandom_range(0, 40)), 16'($urandom_range(0, 4)),
				8'($urandom_range(0, 3)));
			case ($urandom_range(0, 2))
				0: send_gap_max = 0;
				1: send_gap_max = 3;
				default: send_gap_max = 11;
			endcase
			case ($urandom_range(0, 2))
				0: rcv_stall_max = 0;
				1: rcv_stall_max = 3;
				default: rcv_stall_max = 11;
			endcase
			phase_start = items_sent;
			phase_len   = $urandom_range(30, 80);
			while (items_sent - phase_start < phase_len
					&& items_sent - base_items < RANDOM_ITEMS) begin
				// now and then hold off until the unit has caught up
				if ($urandom_range(0, 9) == 0)
					drain();
				random_gesture();
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// File: sim.f
rtl/bgc_pkg.sv
rtl/bgc_ifs.sv
rtl/bgc_cfg.sv
rtl/bgc_core.sv
rtl/bgc_resq.sv
rtl/button_gesture_classifier_unit.sv
rtl/bgc_checker.sv
tb/button_gesture_classifier_unit_tb.sv
